// ----- rtl/bvm_pkg.sv -----
`default_nettype none
package bvm_pkg;
  localparam int MemBytes = 4096;
  localparam int StackDepth = 16;
  localparam int ScreenRows = 32;
  localparam int FontBase = 80;

  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_ROW = 2'd3;

  localparam logic [3:0] G_SYS = 4'h0;
  localparam logic [3:0] G_JUMP = 4'h1;
  localparam logic [3:0] G_CALL = 4'h2;
  localparam logic [3:0] G_SKIP_EQ = 4'h3;
  localparam logic [3:0] G_SKIP_NE = 4'h4;
  localparam logic [3:0] G_SKIP_REQ = 4'h5;
  localparam logic [3:0] G_LOAD_IMM = 4'h6;
  localparam logic [3:0] G_ADD_IMM = 4'h7;
  localparam logic [3:0] G_ALU = 4'h8;
  localparam logic [3:0] G_SKIP_RNE = 4'h9;
  localparam logic [3:0] G_SET_INDEX = 4'hA;
  localparam logic [3:0] G_JUMP_V0 = 4'hB;
  localparam logic [3:0] G_RANDOM = 4'hC;
  localparam logic [3:0] G_DRAW = 4'hD;
  localparam logic [3:0] G_KEY = 4'hE;
  localparam logic [3:0] G_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [3:0] VF = 4'hF;

  localparam logic [15:0] I_CLEAR = 16'h00E0;
  localparam logic [15:0] I_RETURN = 16'h00EE;
  localparam logic [7:0] EX_KEY_DOWN = 8'h9E;
  localparam logic [7:0] EX_KEY_UP = 8'hA1;
  localparam logic [7:0] FX_GET_DELAY = 8'h07;
  localparam logic [7:0] FX_WAIT_KEY = 8'h0A;
  localparam logic [7:0] FX_SET_DELAY = 8'h15;
  localparam logic [7:0] FX_SET_SOUND = 8'h18;
  localparam logic [7:0] FX_ADD_INDEX = 8'h1E;
  localparam logic [7:0] FX_GLYPH = 8'h29;
  localparam logic [7:0] FX_BCD = 8'h33;
  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD = 8'h65;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EXEC,
    ST_WIPE,
    ST_DRAW_MEM,
    ST_DRAW_ROW,
    ST_DRAW_WRITE,
    ST_BCD,
    ST_STORE,
    ST_LOAD_REQ,
    ST_LOAD_WRITE,
    ST_RD_WAIT,
    ST_ROW_WAIT,
    ST_RESULT
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/byte_vm_instruction_unit.sv -----
`default_nettype none
// Instruction unit of the classic hex-keypad byte virtual machine.
// The slave stream carries one transaction per item: tuser selects execute,
// memory write, memory read or frame row read; tdata carries the payload.
// The master stream returns exactly one transaction per accepted item with
// pc, index, read byte, frame row, sound timer and status flags.
// Items are handled one at a time. A loader write goes straight to the
// result state; a memory read, a frame row read or a simple instruction
// first passes a wait or execute state. A sprite draw does a
// read-modify-write of one frame row per sprite line through the frame
// memory. BCD writes three digits, FX55 stores V0 to VX, FX65 loads them,
// and a screen clear walks all 32 rows.
// The block returns to idle after each result transaction before the
// next item is taken.
// After reset the block clears byte memory (the frame clear runs in the
// same sweep) with tready low; the stack and data registers are
// flip-flops cleared at once. When the receiver stalls, the result is
// held on the master side and no new item is taken.
module byte_vm_instruction_unit #(
  parameter int MEM_BYTES = bvm_pkg::MemBytes,
  parameter int STACK_DEPTH = bvm_pkg::StackDepth,
  parameter int SCREEN_ROWS = bvm_pkg::ScreenRows,
  parameter int FONT_BASE = bvm_pkg::FontBase
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // instruction_word, mem_address, write_byte, random_byte, keys_down,
  // key_code, zero fill
  input  wire logic [71:0]  s_axis_tdata,
  // operation
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // next_pc, index_value, read_byte, frame_row, sound_value, frame_changed,
  // waiting_key, stack_fault, zero fill
  output logic [111:0]      m_axis_tdata
);
  localparam int MA = $clog2(MEM_BYTES);
  localparam int RA = $clog2(SCREEN_ROWS);

  bvm_pkg::state_t state, state_next;

  logic [15:0] instr;
  logic [11:0] addr_in;
  logic [7:0]  wbyte, rnd;
  logic [15:0] keys;
  logic [3:0]  kcode;

  logic [7:0]  vreg [16];
  logic [11:0] stack [16];
  logic [4:0]  level;
  logic [11:0] pc, index;
  logic [7:0]  delay, sound;

  logic [7:0]  rbyte;
  logic [63:0] frow;
  logic        changed, waiting, fault;

  logic [3:0]  cnt;
  logic        hit;
  logic [12:0] sweep;
  logic [7:0]  sprite;

  logic          mwe;
  logic [MA-1:0] mwaddr, mraddr;
  logic [7:0]    mwdata, mrdata;
  logic          fwe;
  logic [RA-1:0] fwaddr, fraddr;
  logic [63:0]   fwdata, frdata;

  bvm_ram #(.Width(8), .Depth(MEM_BYTES)) u_mem (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
    .raddr(mraddr), .rdata(mrdata)
  );
  bvm_ram #(.Width(64), .Depth(SCREEN_ROWS)) u_frame (
    .clk(clk), .we(fwe), .waddr(fwaddr), .wdata(fwdata),
    .raddr(fraddr), .rdata(frdata)
  );

  logic [3:0]  x, y, n;
  logic [7:0]  nn, vx, vy;
  logic [11:0] nnn, pc2;
  logic [11:0] a_cnt;
  logic        a_ok;
  logic [4:0]  fy;
  logic [5:0]  sx;
  logic [63:0] spr_mask;
  logic [7:0]  hund, tens, ones;
  logic [8:0]  sum9;

  assign x = instr[11:8];
  assign y = instr[7:4];
  assign n = instr[3:0];
  assign nn = instr[7:0];
  assign nnn = instr[11:0];
  assign vx = vreg[x];
  assign vy = vreg[y];
  assign pc2 = pc + 12'd2;
  assign a_cnt = index + {8'd0, cnt};
  assign a_ok = ({20'd0, a_cnt} < 32'(MEM_BYTES));
  assign fy = 5'(vy[4:0] + {1'b0, cnt});
  assign sx = vx[5:0];
  assign spr_mask = ({sprite, 56'd0} >> sx) | ({sprite, 56'd0} << (7'd64 - {1'b0, sx}));
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
  always_comb begin
    logic [7:0] r;
    r = vx - 8'(hund * 8'd100);
    tens = 8'(({8'd0, r} * 16'd205) >> 11);
    ones = r - 8'(tens * 8'd10);
  end

  assign s_axis_tready = (state == bvm_pkg::ST_IDLE) && !rst;
  assign m_axis_tvalid = (state == bvm_pkg::ST_RESULT);
  assign m_axis_tdata = {5'd0, fault, waiting, changed, sound, frow, rbyte, index, pc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvm_pkg::ST_CLEAR;
      sweep <= '0;
    end else begin
      state <= state_next;
      if (state == bvm_pkg::ST_CLEAR || state == bvm_pkg::ST_WIPE) begin
        sweep <= sweep + 13'd1;
      end else begin
        sweep <= '0;
      end
    end
  end

  bvm_pkg::state_t exec_state;
  always_comb begin
    exec_state = bvm_pkg::ST_RESULT;
    if (instr == bvm_pkg::I_CLEAR) exec_state = bvm_pkg::ST_WIPE;
    else if (instr[15:12] == bvm_pkg::G_DRAW) exec_state = bvm_pkg::ST_DRAW_MEM;
    else if (instr[15:12] == bvm_pkg::G_MISC && nn == bvm_pkg::FX_BCD)
      exec_state = bvm_pkg::ST_BCD;
    else if (instr[15:12] == bvm_pkg::G_MISC && nn == bvm_pkg::FX_STORE)
      exec_state = bvm_pkg::ST_STORE;
    else if (instr[15:12] == bvm_pkg::G_MISC && nn == bvm_pkg::FX_LOAD)
      exec_state = bvm_pkg::ST_LOAD_REQ;
  end

  always_comb begin
    state_next = state;
    mwe = 1'b0;
    mwaddr = addr_in[MA-1:0];
    mwdata = wbyte;
    mraddr = addr_in[MA-1:0];
    fwe = 1'b0;
    fwaddr = fy[RA-1:0];
    fwdata = frdata ^ spr_mask;
    fraddr = fy[RA-1:0];
    unique case (state)
      bvm_pkg::ST_IDLE: begin
        mraddr = s_axis_tdata[16 +: MA];
        fraddr = s_axis_tdata[16 +: RA];
      end
      bvm_pkg::ST_CLEAR: begin
        mwe = ({19'd0, sweep} < 32'(MEM_BYTES));
        mwaddr = sweep[MA-1:0];
        mwdata = '0;
        fwe = ({19'd0, sweep} < 32'(SCREEN_ROWS));
        fwaddr = sweep[RA-1:0];
        fwdata = '0;
        if ({19'd0, sweep} >= 32'(MEM_BYTES)) begin
          state_next = bvm_pkg::ST_IDLE;
        end
      end
      bvm_pkg::ST_EXEC: state_next = exec_state;
      bvm_pkg::ST_WIPE: begin
        fwe = 1'b1;
        fwaddr = sweep[RA-1:0];
        fwdata = '0;
        if ({19'd0, sweep} == 32'(SCREEN_ROWS - 1)) state_next = bvm_pkg::ST_RESULT;
      end
      bvm_pkg::ST_DRAW_MEM: begin
        mraddr = a_cnt[MA-1:0];
        if (cnt == n) state_next = bvm_pkg::ST_RESULT;
        else state_next = bvm_pkg::ST_DRAW_ROW;
      end
      bvm_pkg::ST_DRAW_ROW: state_next = bvm_pkg::ST_DRAW_WRITE;
      bvm_pkg::ST_DRAW_WRITE: begin
        fwe = 1'b1;
        state_next = bvm_pkg::ST_DRAW_MEM;
      end
      bvm_pkg::ST_BCD: begin
        mwe = a_ok;
        mwaddr = a_cnt[MA-1:0];
        mwdata = (cnt == 4'd0) ? hund : (cnt == 4'd1) ? tens : ones;
        if (cnt == 4'd2) state_next = bvm_pkg::ST_RESULT;
      end
      bvm_pkg::ST_STORE: begin
        mwe = a_ok;
        mwaddr = a_cnt[MA-1:0];
        mwdata = vreg[cnt];
        if (cnt == x) state_next = bvm_pkg::ST_RESULT;
      end
      bvm_pkg::ST_LOAD_REQ: begin
        mraddr = a_cnt[MA-1:0];
        state_next = bvm_pkg::ST_LOAD_WRITE;
      end
      bvm_pkg::ST_LOAD_WRITE: begin
        if (cnt == x) state_next = bvm_pkg::ST_RESULT;
        else state_next = bvm_pkg::ST_LOAD_REQ;
      end
      bvm_pkg::ST_RD_WAIT: state_next = bvm_pkg::ST_RESULT;
      bvm_pkg::ST_ROW_WAIT: state_next = bvm_pkg::ST_RESULT;
      bvm_pkg::ST_RESULT: begin
        if (m_axis_tready) state_next = bvm_pkg::ST_IDLE;
      end
      default: state_next = bvm_pkg::ST_IDLE;
    endcase
    if (state == bvm_pkg::ST_IDLE && s_axis_tvalid) begin
      unique case (s_axis_tuser)
        bvm_pkg::OP_WRITE: begin
          mwe = ({20'd0, s_axis_tdata[27:16]} < 32'(MEM_BYTES));
          mwaddr = s_axis_tdata[16 +: MA];
          mwdata = s_axis_tdata[35:28];
          state_next = bvm_pkg::ST_RESULT;
        end
        bvm_pkg::OP_READ: state_next = bvm_pkg::ST_RD_WAIT;
        bvm_pkg::OP_ROW: state_next = bvm_pkg::ST_ROW_WAIT;
        default: state_next = bvm_pkg::ST_EXEC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        vreg[i] <= '0;
        stack[i] <= '0;
      end
      level <= '0;
      pc <= 12'h200;
      index <= '0;
      delay <= '0;
      sound <= '0;
    end else begin
      if (state == bvm_pkg::ST_IDLE && s_axis_tvalid) begin
        instr <= s_axis_tdata[15:0];
        addr_in <= s_axis_tdata[27:16];
        wbyte <= s_axis_tdata[35:28];
        rnd <= s_axis_tdata[43:36];
        keys <= s_axis_tdata[59:44];
        kcode <= s_axis_tdata[63:60];
        rbyte <= '0;
        frow <= '0;
        changed <= 1'b0;
        waiting <= 1'b0;
        fault <= 1'b0;
        cnt <= '0;
        hit <= 1'b0;
      end
      if (state == bvm_pkg::ST_RD_WAIT) begin
        rbyte <= ({20'd0, addr_in} < 32'(MEM_BYTES)) ? mrdata : 8'd0;
      end
      if (state == bvm_pkg::ST_ROW_WAIT) frow <= frdata;
      if (state == bvm_pkg::ST_DRAW_MEM) begin
        sprite <= '0;
      end
      if (state == bvm_pkg::ST_DRAW_ROW) begin
        sprite <= a_ok ? mrdata : 8'd0;
      end
      if (state == bvm_pkg::ST_DRAW_WRITE) begin
        if ((frdata & spr_mask) != 64'd0) hit <= 1'b1;
        cnt <= cnt + 4'd1;
      end
      if (state == bvm_pkg::ST_DRAW_MEM && cnt == n) begin
        vreg[bvm_pkg::VF] <= {7'd0, hit};
      end
      if (state == bvm_pkg::ST_BCD) cnt <= cnt + 4'd1;
      if (state == bvm_pkg::ST_STORE) begin
        cnt <= cnt + 4'd1;
        if (cnt == x) index <= index + {8'd0, x} + 12'd1;
      end
      if (state == bvm_pkg::ST_LOAD_WRITE) begin
        vreg[cnt] <= a_ok ? mrdata : 8'd0;
        cnt <= cnt + 4'd1;
      end
      if (state == bvm_pkg::ST_EXEC) begin
        pc <= pc2;
        unique case (instr[15:12])
          bvm_pkg::G_SYS: begin
            if (instr == bvm_pkg::I_CLEAR) begin
              changed <= 1'b1;
            end else if (instr == bvm_pkg::I_RETURN) begin
              if (level == 5'd0 || {27'd0, level} > 32'(STACK_DEPTH)) begin
                fault <= 1'b1;
              end else begin
                pc <= stack[4'(level - 5'd1)];
                stack[4'(level - 5'd1)] <= '0;
                level <= level - 5'd1;
              end
            end
          end
          bvm_pkg::G_JUMP: pc <= nnn;
          bvm_pkg::G_CALL: begin
            if ({27'd0, level} >= 32'(STACK_DEPTH)) begin
              fault <= 1'b1;
            end else begin
              stack[level[3:0]] <= pc2;
              level <= level + 5'd1;
              pc <= nnn;
            end
          end
          bvm_pkg::G_SKIP_EQ: if (vx == nn) pc <= pc + 12'd4;
          bvm_pkg::G_SKIP_NE: if (vx != nn) pc <= pc + 12'd4;
          bvm_pkg::G_SKIP_REQ: if (n == 4'd0 && vx == vy) pc <= pc + 12'd4;
          bvm_pkg::G_LOAD_IMM: vreg[x] <= nn;
          bvm_pkg::G_ADD_IMM: vreg[x] <= vx + nn;
          bvm_pkg::G_ALU: begin
            unique case (n)
              bvm_pkg::ALU_MOV: vreg[x] <= vy;
              bvm_pkg::ALU_OR: begin vreg[x] <= vx | vy; vreg[bvm_pkg::VF] <= '0; end
              bvm_pkg::ALU_AND: begin vreg[x] <= vx & vy; vreg[bvm_pkg::VF] <= '0; end
              bvm_pkg::ALU_XOR: begin vreg[x] <= vx ^ vy; vreg[bvm_pkg::VF] <= '0; end
              bvm_pkg::ALU_ADD: begin
                vreg[x] <= sum9[7:0];
                vreg[bvm_pkg::VF] <= {7'd0, sum9[8]};
              end
              bvm_pkg::ALU_SUB: begin
                vreg[x] <= vx - vy;
                vreg[bvm_pkg::VF] <= {7'd0, vx >= vy};
              end
              bvm_pkg::ALU_SHR: begin
                vreg[x] <= vy >> 1;
                vreg[bvm_pkg::VF] <= {7'd0, vy[0]};
              end
              bvm_pkg::ALU_SUBN: begin
                vreg[x] <= vy - vx;
                vreg[bvm_pkg::VF] <= {7'd0, vy >= vx};
              end
              bvm_pkg::ALU_SHL: begin
                vreg[x] <= vy << 1;
                vreg[bvm_pkg::VF] <= {7'd0, vy[7]};
              end
              default: ;
            endcase
          end
          bvm_pkg::G_SKIP_RNE: if (n == 4'd0 && vx != vy) pc <= pc + 12'd4;
          bvm_pkg::G_SET_INDEX: index <= nnn;
          bvm_pkg::G_JUMP_V0: pc <= nnn + {4'd0, vreg[0]};
          bvm_pkg::G_RANDOM: vreg[x] <= nn & rnd;
          bvm_pkg::G_DRAW: if (n != 4'd0) changed <= 1'b1;
          bvm_pkg::G_KEY: begin
            if (nn == bvm_pkg::EX_KEY_DOWN && keys[vx[3:0]]) pc <= pc + 12'd4;
            if (nn == bvm_pkg::EX_KEY_UP && !keys[vx[3:0]]) pc <= pc + 12'd4;
          end
          default: begin
            unique case (nn)
              bvm_pkg::FX_GET_DELAY: vreg[x] <= delay;
              bvm_pkg::FX_WAIT_KEY: begin
                if (kcode == 4'd0) begin
                  pc <= pc;
                  waiting <= 1'b1;
                end else begin
                  vreg[x] <= {4'd0, kcode};
                end
              end
              bvm_pkg::FX_SET_DELAY: delay <= vx;
              bvm_pkg::FX_SET_SOUND: sound <= vx;
              bvm_pkg::FX_ADD_INDEX: index <= index + {4'd0, vx};
              bvm_pkg::FX_GLYPH:
                index <= 12'(FONT_BASE) + 12'({2'b00, vx[3:0], 2'b00} + {4'd0, vx[3:0]});
              default: ;
            endcase
          end
        endcase
      end
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid));
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    {27'd0, level} <= 32'(STACK_DEPTH));
  a_reset_busy: assert property (@(posedge clk) rst |=> !s_axis_tready && !m_axis_tvalid);

endmodule
`default_nettype wire

// ----- rtl/bvm_ram.sv -----
`default_nettype none
module bvm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- bench/byte_vm_instruction_unit_tb.sv -----
module byte_vm_instruction_unit_tb;

  typedef struct {
    logic [11:0] pc;
    logic [11:0] idx;
    logic [7:0]  rbyte;
    logic [63:0] row;
    logic [7:0]  sound;
    logic        changed;
    logic        key_wait;
    logic        fault;
  } vm_result_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  logic [7:0]  vreg [16];
  logic [11:0] index_r;
  logic [11:0] pc_r;
  logic [11:0] call_stack [16];
  int          depth;
  logic [7:0]  delay_r;
  logic [7:0]  sound_r;
  logic [7:0]  mem_image [4096];
  logic [63:0] screen [32];

  vm_result_t result_q[$];
  int errors = 0;
  int burst_left = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  byte_vm_instruction_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic execute_model(input logic [1:0] op, input logic [15:0] w,
                               input logic [11:0] addr, input logic [7:0] wbyte,
                               input logic [7:0] rnd, input logic [15:0] keys,
                               input logic [3:0] kcode);
    vm_result_t r;
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy, bits;
    logic [11:0] nnn;
    logic [8:0] sum;
    logic hit;
    int fy, fx;
    r = '{default: '0};
    x = w[11:8];
    y = w[7:4];
    n = w[3:0];
    nn = w[7:0];
    nnn = w[11:0];
    vx = vreg[x];
    vy = vreg[y];
    if (op == bvm_pkg::OP_WRITE) begin
      mem_image[addr] = wbyte;
    end else if (op == bvm_pkg::OP_READ) begin
      r.rbyte = mem_image[addr];
    end else if (op == bvm_pkg::OP_ROW) begin
      r.row = screen[addr[4:0]];
    end else begin
      pc_r = pc_r + 12'd2;
      case (w[15:12])
        bvm_pkg::G_SYS: begin
          if (w == bvm_pkg::I_CLEAR) begin
            foreach (screen[i]) screen[i] = '0;
            r.changed = 1'b1;
          end else if (w == bvm_pkg::I_RETURN) begin
            if (depth == 0) begin
              r.fault = 1'b1;
            end else begin
              depth--;
              pc_r = call_stack[depth];
              call_stack[depth] = '0;
            end
          end
        end
        bvm_pkg::G_JUMP: pc_r = nnn;
        bvm_pkg::G_CALL: begin
          if (depth >= bvm_pkg::StackDepth) begin
            r.fault = 1'b1;
          end else begin
            call_stack[depth] = pc_r;
            depth++;
            pc_r = nnn;
          end
        end
        bvm_pkg::G_SKIP_EQ: if (vx == nn) pc_r = pc_r + 12'd2;
        bvm_pkg::G_SKIP_NE: if (vx != nn) pc_r = pc_r + 12'd2;
        bvm_pkg::G_SKIP_REQ: if (n == 4'd0 && vx == vy) pc_r = pc_r + 12'd2;
        bvm_pkg::G_LOAD_IMM: vreg[x] = nn;
        bvm_pkg::G_ADD_IMM: vreg[x] = vx + nn;
        bvm_pkg::G_ALU: begin
          case (n)
            bvm_pkg::ALU_MOV: vreg[x] = vy;
            bvm_pkg::ALU_OR: begin vreg[x] = vx | vy; vreg[bvm_pkg::VF] = 8'd0; end
            bvm_pkg::ALU_AND: begin vreg[x] = vx & vy; vreg[bvm_pkg::VF] = 8'd0; end
            bvm_pkg::ALU_XOR: begin vreg[x] = vx ^ vy; vreg[bvm_pkg::VF] = 8'd0; end
            bvm_pkg::ALU_ADD: begin
              sum = {1'b0, vx} + {1'b0, vy};
              vreg[x] = sum[7:0];
              vreg[bvm_pkg::VF] = {7'd0, sum[8]};
            end
            bvm_pkg::ALU_SUB: begin
              vreg[x] = vx - vy;
              vreg[bvm_pkg::VF] = {7'd0, vx >= vy};
            end
            bvm_pkg::ALU_SHR: begin
              vreg[x] = vy >> 1;
              vreg[bvm_pkg::VF] = {7'd0, vy[0]};
            end
            bvm_pkg::ALU_SUBN: begin
              vreg[x] = vy - vx;
              vreg[bvm_pkg::VF] = {7'd0, vy >= vx};
            end
            bvm_pkg::ALU_SHL: begin
              vreg[x] = vy << 1;
              vreg[bvm_pkg::VF] = {7'd0, vy[7]};
            end
            default: ;
          endcase
        end
        bvm_pkg::G_SKIP_RNE: if (n == 4'd0 && vx != vy) pc_r = pc_r + 12'd2;
        bvm_pkg::G_SET_INDEX: index_r = nnn;
        bvm_pkg::G_JUMP_V0: pc_r = nnn + {4'd0, vreg[0]};
        bvm_pkg::G_RANDOM: vreg[x] = nn & rnd;
        bvm_pkg::G_DRAW: begin
          hit = 1'b0;
          if (n != 4'd0) r.changed = 1'b1;
          for (int row = 0; row < n; row++) begin
            bits = mem_image[12'(index_r + row)];
            fy = (vy + row) % 32;
            for (int col = 0; col < 8; col++) begin
              if (bits[7 - col]) begin
                fx = (vx + col) & 63;
                if (screen[fy][63 - fx]) hit = 1'b1;
                screen[fy][63 - fx] = ~screen[fy][63 - fx];
              end
            end
          end
          vreg[bvm_pkg::VF] = {7'd0, hit};
        end
        bvm_pkg::G_KEY: begin
          if (nn == bvm_pkg::EX_KEY_DOWN) begin
            if (keys[vx[3:0]]) pc_r = pc_r + 12'd2;
          end else if (nn == bvm_pkg::EX_KEY_UP) begin
            if (!keys[vx[3:0]]) pc_r = pc_r + 12'd2;
          end
        end
        default: begin
          case (nn)
            bvm_pkg::FX_GET_DELAY: vreg[x] = delay_r;
            bvm_pkg::FX_WAIT_KEY: begin
              if (kcode == 4'd0) begin
                pc_r = pc_r - 12'd2;
                r.key_wait = 1'b1;
              end else begin
                vreg[x] = {4'd0, kcode};
              end
            end
            bvm_pkg::FX_SET_DELAY: delay_r = vx;
            bvm_pkg::FX_SET_SOUND: sound_r = vx;
            bvm_pkg::FX_ADD_INDEX: index_r = index_r + {4'd0, vx};
            bvm_pkg::FX_GLYPH: index_r = 12'(bvm_pkg::FontBase + 5 * vx[3:0]);
            bvm_pkg::FX_BCD: begin
              mem_image[index_r] = vx / 8'd100;
              mem_image[12'(index_r + 1)] = (vx / 8'd10) % 8'd10;
              mem_image[12'(index_r + 2)] = vx % 8'd10;
            end
            bvm_pkg::FX_STORE: begin
              for (int i = 0; i <= x; i++) mem_image[12'(index_r + i)] = vreg[i];
              index_r = index_r + {8'd0, x} + 12'd1;
            end
            bvm_pkg::FX_LOAD: begin
              for (int i = 0; i <= x; i++) vreg[i] = mem_image[12'(index_r + i)];
            end
            default: ;
          endcase
        end
      endcase
    end
    r.pc = pc_r;
    r.idx = index_r;
    r.sound = sound_r;
    result_q.push_back(r);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [15:0] w,
                           input logic [11:0] addr, input logic [7:0] wbyte,
                           input logic [7:0] rnd, input logic [15:0] keys,
                           input logic [3:0] kcode);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {8'd0, kcode, keys, rnd, wbyte, addr, w};
    do @(posedge clk); while (!s_axis_tready);
    execute_model(op, w, addr, wbyte, rnd, keys, kcode);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= 2'($urandom);
        s_axis_tdata <= 72'({$urandom, $urandom, $urandom});
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic run_exec(input logic [15:0] w);
    send_item(bvm_pkg::OP_EXEC, w, 12'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 4'($urandom_range(1, 15)));
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    vm_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata[63:0], '0);
      end else begin
        e = result_q.pop_front();
        if (m_axis_tdata[11:0] !== e.pc)
          report_mismatch("next_pc", 64'(m_axis_tdata[11:0]), 64'(e.pc));
        if (m_axis_tdata[23:12] !== e.idx)
          report_mismatch("index_value", 64'(m_axis_tdata[23:12]), 64'(e.idx));
        if (m_axis_tdata[31:24] !== e.rbyte)
          report_mismatch("read_byte", 64'(m_axis_tdata[31:24]), 64'(e.rbyte));
        if (m_axis_tdata[95:32] !== e.row)
          report_mismatch("frame_row", m_axis_tdata[95:32], e.row);
        if (m_axis_tdata[103:96] !== e.sound)
          report_mismatch("sound_value", 64'(m_axis_tdata[103:96]), 64'(e.sound));
        if (m_axis_tdata[104] !== e.changed)
          report_mismatch("frame_changed", 64'(m_axis_tdata[104]), 64'(e.changed));
        if (m_axis_tdata[105] !== e.key_wait)
          report_mismatch("waiting_key", 64'(m_axis_tdata[105]), 64'(e.key_wait));
        if (m_axis_tdata[106] !== e.fault)
          report_mismatch("stack_fault", 64'(m_axis_tdata[106]), 64'(e.fault));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_cnt <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(10, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic test_loader;
    send_item(bvm_pkg::OP_WRITE, 16'hFFFF, 12'h000, 8'hFF, 8'h00, 16'h0000, 4'h0);
    send_item(bvm_pkg::OP_WRITE, 16'h0000, 12'hFFF, 8'hA5, 8'hFF, 16'hFFFF, 4'hF);
    send_item(bvm_pkg::OP_READ, 16'h0000, 12'hFFF, 8'h00, 8'h00, 16'h0000, 4'h0);
    send_item(bvm_pkg::OP_READ, 16'h0000, 12'h000, 8'h00, 8'h00, 16'h0000, 4'h0);
    send_item(bvm_pkg::OP_ROW, 16'h0000, 12'hFFF, 8'h00, 8'h00, 16'h0000, 4'h0);
  endtask

  task automatic test_alu;
    run_exec(16'h60FF);
    run_exec(16'h6101);
    run_exec(16'h8014);
    run_exec(16'h8F15);
    run_exec(16'h8017);
    run_exec(16'h8106);
    run_exec(16'h810E);
    run_exec(16'h8011);
    send_item(bvm_pkg::OP_EXEC, 16'hC2F0, 12'h0, 8'h0, 8'h5A, 16'h0, 4'h1);
  endtask

  task automatic test_flow;
    run_exec(16'h2ABC);
    run_exec(bvm_pkg::I_RETURN);
    run_exec(bvm_pkg::I_RETURN);
    run_exec(16'h3000);
    run_exec(16'hBFFF);
    run_exec(16'h1FFE);
  endtask

  task automatic test_draw;
    run_exec(16'hA000);
    run_exec(16'h603E);
    run_exec(16'h611F);
    run_exec(16'hD012);
    run_exec(16'hD01F);
    send_item(bvm_pkg::OP_ROW, 16'h0, 12'h000, 8'h0, 8'h0, 16'h0, 4'h0);
    run_exec(16'hD010);
    run_exec(bvm_pkg::I_CLEAR);
  endtask

  task automatic test_keys_and_memory;
    send_item(bvm_pkg::OP_EXEC, 16'hF00A, 12'h0, 8'h0, 8'h0, 16'h0, 4'h0);
    send_item(bvm_pkg::OP_EXEC, 16'hF30A, 12'h0, 8'h0, 8'h0, 16'h0, 4'h5);
    send_item(bvm_pkg::OP_EXEC, 16'hE39E, 12'h0, 8'h0, 8'h0, 16'h0020, 4'h1);
    send_item(bvm_pkg::OP_EXEC, 16'hE3A1, 12'h0, 8'h0, 8'h0, 16'h0020, 4'h1);
    run_exec(16'hF029);
    run_exec(16'hAFFE);
    run_exec(16'hF033);
    run_exec(16'hF255);
    run_exec(16'hF165);
    run_exec(16'hF018);
    run_exec(16'hF015);
    run_exec(16'hF207);
    run_exec(16'hF01E);
  endtask

  function automatic logic [15:0] random_instruction;
    logic [3:0] grp;
    logic [15:0] w;
    grp = 4'($urandom);
    w = {grp, 12'($urandom)};
    case (grp)
      bvm_pkg::G_SYS: begin
        case ($urandom_range(0, 3))
          0: w = bvm_pkg::I_CLEAR;
          1, 2: w = bvm_pkg::I_RETURN;
          default: ;
        endcase
      end
      bvm_pkg::G_SKIP_REQ, bvm_pkg::G_SKIP_RNE: if ($urandom_range(0, 3) != 0) w[3:0] = 4'h0;
      bvm_pkg::G_DRAW:
        w[3:0] = ($urandom_range(0, 9) == 0) ? 4'hF : 4'($urandom_range(0, 4));
      bvm_pkg::G_KEY: begin
        case ($urandom_range(0, 4))
          0, 1: w[7:0] = bvm_pkg::EX_KEY_DOWN;
          2, 3: w[7:0] = bvm_pkg::EX_KEY_UP;
          default: ;
        endcase
      end
      bvm_pkg::G_MISC: begin
        case ($urandom_range(0, 9))
          0: w[7:0] = bvm_pkg::FX_GET_DELAY;
          1: w[7:0] = bvm_pkg::FX_WAIT_KEY;
          2: w[7:0] = bvm_pkg::FX_SET_DELAY;
          3: w[7:0] = bvm_pkg::FX_SET_SOUND;
          4: w[7:0] = bvm_pkg::FX_ADD_INDEX;
          5: w[7:0] = bvm_pkg::FX_GLYPH;
          6: w[7:0] = bvm_pkg::FX_BCD;
          7: w[7:0] = bvm_pkg::FX_STORE;
          8: w[7:0] = bvm_pkg::FX_LOAD;
          default: ;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic random_item;
    logic [1:0] op;
    int pick;
    pick = $urandom_range(0, 99);
    op = (pick < 80) ? bvm_pkg::OP_EXEC : (pick < 88) ? bvm_pkg::OP_WRITE :
         (pick < 94) ? bvm_pkg::OP_READ : bvm_pkg::OP_ROW;
    send_item(op, (op == bvm_pkg::OP_EXEC) ? random_instruction() : 16'($urandom),
              12'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
              ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom));
  endtask

  task automatic test_stack_limits;
    for (int i = 0; i < 17; i++) run_exec({bvm_pkg::G_CALL, 12'($urandom)});
    for (int i = 0; i < 17; i++) run_exec(bvm_pkg::I_RETURN);
  endtask

  task automatic test_random;
    for (int i = 0; i < 1700; i++) begin
      random_item();
      if (i == 800) test_stack_limits();
    end
  endtask

  task automatic test_backpressure;
    hold_token++;
    for (int i = 0; i < 12; i++) random_item();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    index_r = '0;
    pc_r = 12'h200;
    depth = 0;
    delay_r = '0;
    sound_r = '0;
    foreach (vreg[i]) vreg[i] = '0;
    foreach (call_stack[i]) call_stack[i] = '0;
    foreach (mem_image[i]) mem_image[i] = '0;
    foreach (screen[i]) screen[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_loader();
    test_alu();
    test_flow();
    test_draw();
    test_keys_and_memory();
    test_backpressure();
    test_random();
    test_backpressure();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/bvm_pkg.sv
rtl/bvm_ram.sv
rtl/byte_vm_instruction_unit.sv
bench/byte_vm_instruction_unit_tb.sv
